// File: hdl/lgge_pkg.sv
package lgge_pkg;

    // Command codes
    localparam logic [2:0] CMD_SET     = 3'd0;
    localparam logic [2:0] CMD_EVOLVE  = 3'd1;
    localparam logic [2:0] CMD_CLEAR   = 3'd2;
    localparam logic [2:0] CMD_RESTORE = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    // Neighbour counts of the B3/S23 rule
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

    // Control that the sequencer hands to the rule unit for one row step
    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] column;
        logic       in_grid;
        logic       row_hit;
        logic       value;
        logic       evolve_en;
    } lgge_ctrl_t;

endpackage

// File: hdl/lgge_row_cell.sv
module lgge_row_cell #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift_en,
    input  logic [W-1:0] grid_in,
    input  logic [W-1:0] saved_in,
    output logic [W-1:0] grid_out,
    output logic [W-1:0] saved_out
);

    logic [W-1:0] grid_reg;
    logic [W-1:0] saved_reg;

    // Take the neighbour's row on every step of a command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg  <= '0;
            saved_reg <= '0;
        end
        else if (shift_en)
        begin
            grid_reg  <= grid_in;
            saved_reg <= saved_in;
        end
    end

    assign grid_out  = grid_reg;
    assign saved_out = saved_reg;

endmodule

// File: hdl/lgge_rule_unit.sv
module lgge_rule_unit #(
    parameter int COLS = 64
) (
    input  lgge_pkg::lgge_ctrl_t ctrl,
    input  logic [COLS-1:0]      up_row,
    input  logic [COLS-1:0]      mid_grid,
    input  logic [COLS-1:0]      mid_saved,
    input  logic [COLS-1:0]      down_row,
    output logic [COLS-1:0]      grid_new,
    output logic [COLS-1:0]      saved_new,
    output logic                 alive
);

    import lgge_pkg::*;

    logic [COLS+1:0] up_x;
    logic [COLS+1:0] mid_x;
    logic [COLS+1:0] down_x;
    logic [COLS-1:0] life_row;
    logic [COLS-1:0] bit_mask;
    logic [COLS-1:0] set_row;

    // Pad with dead cells beyond both edges
    assign up_x   = {1'b0, up_row, 1'b0};
    assign mid_x  = {1'b0, mid_grid, 1'b0};
    assign down_x = {1'b0, down_row, 1'b0};

    // Next generation, computed for every column in parallel
    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        logic [3:0] nbr;
        assign nbr = 4'($countones({up_x[c+2:c], mid_x[c+2], mid_x[c], down_x[c+2:c]}));
        assign life_row[c] = (nbr == NBR_BIRTH) || ((nbr == NBR_KEEP) && mid_grid[c]);
    end

    assign bit_mask = {{(COLS-1){1'b0}}, 1'b1} << ctrl.column;
    assign set_row  = ctrl.value ? (mid_grid | bit_mask) : (mid_grid & ~bit_mask);

    // Apply the command to the row at the head of the chain
    always_comb
    begin
        grid_new  = mid_grid;
        saved_new = mid_saved;
        alive     = 1'b0;
        case (ctrl.cmd)
            CMD_SET:
            begin
                if (ctrl.in_grid)
                begin
                    grid_new  = ctrl.row_hit ? set_row : mid_grid;
                    saved_new = ctrl.row_hit ? set_row : mid_grid;
                    alive     = ctrl.row_hit && ctrl.value;
                end
            end
            CMD_EVOLVE:
            begin
                if (ctrl.evolve_en)
                    grid_new = life_row;
            end
            CMD_CLEAR:
            begin
                grid_new  = '0;
                saved_new = '0;
            end
            CMD_RESTORE:
            begin
                grid_new = mid_saved;
            end
            CMD_READ:
            begin
                alive = ctrl.row_hit && (|(mid_grid & bit_mask));
            end
            default:
            begin
                grid_new  = mid_grid;
                saved_new = mid_saved;
            end
        endcase
    end

endmodule

// File: hdl/life_grid_generation_engine.sv
// Game-of-life engine (B3/S23) on a COLS x ROWS grid that does not wrap, with a saved
// copy of the grid. The rows sit in a ring of ROWS row cells; every command turns the
// ring once, one row a cycle but for a final step held while out_stall holds a result,
// through a single rule unit at its head, which evolves, sets, clears, restores or
// reads the passing row and notes on the way whether any row is live. A new command
// is taken once the sweep is done and its result is in the output register. A result
// that is held off by out_stall delays the final step of the next command, not its
// acceptance.
module life_grid_generation_engine #(
    parameter int COLS = 64,
    parameter int ROWS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] command,
    input  logic [5:0] column,
    input  logic [4:0] row,
    input  logic       value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       cell_alive,
    output logic       grid_empty,
    output logic       advanced
);

    import lgge_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic            state_reg, state_next;
    logic [RW-1:0]   k_reg;
    logic [2:0]      cmd_reg;
    logic [5:0]      col_reg;
    logic [4:0]      row_reg;
    logic            val_reg;
    logic [COLS-1:0] prev_reg;
    logic            nz_reg;
    logic            alive_acc_reg;
    logic            empty_reg;
    logic            out_valid_reg;
    logic            cell_alive_reg;
    logic            grid_empty_reg;
    logic            advanced_reg;

    logic            in_take;
    logic            out_free;
    logic            last_step;
    logic            shift_en;
    logic            finish;
    logic            in_grid;
    lgge_ctrl_t      ctrl;
    logic [COLS-1:0] grid_q  [ROWS];
    logic [COLS-1:0] saved_q [ROWS];
    logic [COLS-1:0] grid_new;
    logic [COLS-1:0] saved_new;
    logic [COLS-1:0] down_row;
    logic            step_alive;
    logic            step_nz;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_step = (k_reg == LAST_ROW);
    assign shift_en  = (state_reg == S_RUN) && (!last_step || out_free);
    assign finish    = shift_en && last_step;

    // Decode the addressed cell
    assign in_grid = (32'(col_reg) < 32'(COLS)) && (32'(row_reg) < 32'(ROWS));

    assign ctrl.cmd       = cmd_reg;
    assign ctrl.column    = col_reg;
    assign ctrl.in_grid   = in_grid;
    assign ctrl.row_hit   = in_grid && (32'(row_reg) == 32'(k_reg));
    assign ctrl.value     = val_reg;
    assign ctrl.evolve_en = !empty_reg;

    // Row below the head; past the bottom edge it is dead
    assign down_row = last_step ? '0 : grid_q[1];

    // Row ring: each cell takes the row of the one after it, the tail takes the head's result
    for (genvar i = 0; i < ROWS; i++)
    begin : g_ring
        if (i == ROWS - 1)
        begin : g_tail
            lgge_row_cell #(.W(COLS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .grid_in   (grid_new),
                .saved_in  (saved_new),
                .grid_out  (grid_q[i]),
                .saved_out (saved_q[i])
            );
        end
        else
        begin : g_body
            lgge_row_cell #(.W(COLS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .grid_in   (grid_q[i+1]),
                .saved_in  (saved_q[i+1]),
                .grid_out  (grid_q[i]),
                .saved_out (saved_q[i])
            );
        end
    end

    lgge_rule_unit #(.COLS(COLS)) u_rule (
        .ctrl      (ctrl),
        .up_row    (prev_reg),
        .mid_grid  (grid_q[0]),
        .mid_saved (saved_q[0]),
        .down_row  (down_row),
        .grid_new  (grid_new),
        .saved_new (saved_new),
        .alive     (step_alive)
    );

    assign step_nz = |grid_new;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_take) state_next = S_RUN;
            S_RUN:   if (finish)  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            nz_reg        <= 1'b0;
            alive_acc_reg <= 1'b0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Start a command
            if (in_take)
            begin
                k_reg         <= '0;
                nz_reg        <= 1'b0;
                alive_acc_reg <= 1'b0;
            end
            // Advance one row and gather status
            else if (shift_en)
            begin
                k_reg         <= last_step ? '0 : k_reg + 1'b1;
                nz_reg        <= nz_reg | step_nz;
                alive_acc_reg <= alive_acc_reg | step_alive;
            end
            // Hand over the result beat, or drop it once taken
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                empty_reg     <= !(nz_reg || step_nz);
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the command fields and the row above the head
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= command;
            col_reg  <= column;
            row_reg  <= row;
            val_reg  <= value;
            prev_reg <= '0;
        end
        else if (shift_en)
        begin
            prev_reg <= grid_q[0];
        end
    end

    // Result fields
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            cell_alive_reg <= alive_acc_reg || step_alive;
            grid_empty_reg <= !(nz_reg || step_nz);
            advanced_reg   <= (cmd_reg == CMD_EVOLVE) && !empty_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_alive = cell_alive_reg;
    assign grid_empty = grid_empty_reg;
    assign advanced   = advanced_reg;

    // A new result only ever follows the last row step
    a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RUN))
        else $error("result appeared without a command in flight");

    // A live addressed cell means the grid cannot be empty
    a_alive_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cell_alive_reg |-> !grid_empty_reg)
        else $error("live cell reported with an empty grid");

    // The row counter stays on the ring
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> k_reg <= LAST_ROW)
        else $error("row step beyond the last row");

    // An accepted command starts a sweep from the first row
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_RUN) && (k_reg == '0))
        else $error("accepted command did not start a sweep");

endmodule

// File: test/life_grid_generation_engine_test.sv
module life_grid_generation_engine_test;

    import lgge_pkg::*;

    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 32;
    localparam int RANDOM_BEATS = 600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2 * GRID_ROWS + 8;

    // Command codes the block ignores
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [5:0] column;
        logic [4:0] row;
        logic       value;
    } life_cmd_t;

    typedef struct packed {
        logic cell_alive;
        logic grid_empty;
        logic advanced;
    } life_status_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] command = '0;
    logic [5:0] column = '0;
    logic [4:0] row = '0;
    logic       value = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       cell_alive;
    logic       grid_empty;
    logic       advanced;

    life_cmd_t    pending_cmds [$];
    life_status_t expected_status [$];

    // Shadow of the block's grids
    logic [GRID_COLS-1:0] life_grid  [GRID_ROWS];
    logic [GRID_COLS-1:0] saved_grid [GRID_ROWS];
    int unsigned          live_cells;

    int unsigned total_cmds;
    int unsigned cmds_taken;
    int unsigned errors;
    int unsigned cycle_count;
    int unsigned send_gap;
    int unsigned hold_left;
    logic        send_calm;
    logic        recv_calm;

    life_grid_generation_engine uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .column     (column),
        .row        (row),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_alive (cell_alive),
        .grid_empty (grid_empty),
        .advanced   (advanced)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cells beyond the border read as dead
    function automatic logic cell_at(int r, int c);
        if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS)
            return 1'b0;
        return life_grid[r][c];
    endfunction

    function automatic int unsigned count_live();
        int unsigned n;
        n = 0;
        for (int r = 0; r < GRID_ROWS; r++)
            n += $countones(life_grid[r]);
        return n;
    endfunction

    function automatic void step_generation();
        logic [GRID_COLS-1:0] next_rows [GRID_ROWS];
        int                   nbrs;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            for (int c = 0; c < GRID_COLS; c++)
            begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            nbrs += cell_at(r + dr, c + dc);
                next_rows[r][c] = (nbrs == NBR_BIRTH) ||
                                  (nbrs == NBR_KEEP && life_grid[r][c]);
            end
        end
        life_grid = next_rows;
        live_cells = count_live();
    endfunction

    // Apply one command to the shadow grids and return the status it should report
    function automatic life_status_t apply_command(life_cmd_t cmd);
        life_status_t st;
        st = '0;
        case (cmd.command)
            CMD_SET:
            begin
                life_grid[cmd.row][cmd.column] = cmd.value;
                saved_grid = life_grid;
                live_cells = count_live();
                st.cell_alive = cmd.value;
            end
            CMD_EVOLVE:
            begin
                if (live_cells != 0)
                begin
                    step_generation();
                    st.advanced = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                for (int r = 0; r < GRID_ROWS; r++)
                begin
                    life_grid[r] = '0;
                    saved_grid[r] = '0;
                end
                live_cells = 0;
            end
            CMD_RESTORE:
            begin
                life_grid = saved_grid;
                live_cells = count_live();
            end
            CMD_READ:
                st.cell_alive = life_grid[cmd.row][cmd.column];
            default:
                ;
        endcase
        st.grid_empty = (live_cells == 0);
        return st;
    endfunction

    task automatic queue_cmd(logic [2:0] op, int c, int r, logic v);
        life_cmd_t cmd;
        cmd.command = op;
        cmd.column = c[5:0];
        cmd.row = r[4:0];
        cmd.value = v;
        pending_cmds.push_back(cmd);
    endtask

    function automatic int unsigned draw_wait(logic calm);
        if (calm)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Driver: present queued beats, idle between them
    always @(posedge clk or negedge rst_n)
    begin
        life_cmd_t cmd;
        logic      next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            column <= '0;
            row <= '0;
            value <= 1'b0;
            send_gap <= 0;
            send_calm <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                cmd.command = command;
                cmd.column = column;
                cmd.row = row;
                cmd.value = value;
                expected_status.push_back(apply_command(cmd));
                cmds_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
                else if (pending_cmds.size() != 0)
                begin
                    cmd = pending_cmds.pop_front();
                    command <= cmd.command;
                    column <= cmd.column;
                    row <= cmd.row;
                    value <= cmd.value;
                    next_valid = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_calm <= !send_calm;
                    send_gap <= draw_wait(send_calm);
                end
            end
            in_valid <= next_valid;
        end
    end

    // Monitor: check each result beat, hold off the next one at random
    always @(posedge clk or negedge rst_n)
    begin
        life_status_t want;
        int unsigned  hold_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            recv_calm <= 1'b0;
        end
        else
        begin
            hold_next = hold_left;
            if (out_valid && !out_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (cell_alive !== want.cell_alive)
                    begin
                        $error("cell_alive: expected %0b, actual %0b",
                               want.cell_alive, cell_alive);
                        errors++;
                    end
                    if (grid_empty !== want.grid_empty)
                    begin
                        $error("grid_empty: expected %0b, actual %0b",
                               want.grid_empty, grid_empty);
                        errors++;
                    end
                    if (advanced !== want.advanced)
                    begin
                        $error("advanced: expected %0b, actual %0b",
                               want.advanced, advanced);
                        errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_calm <= !recv_calm;
                hold_next = draw_wait(recv_calm);
            end
            else if (out_valid && hold_left != 0)
                hold_next = hold_left - 1;
            hold_left <= hold_next;
            out_stall <= (hold_next != 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int unsigned base_c;
        int unsigned base_r;
        int unsigned pick;
        errors = 0;
        cmds_taken = 0;
        cycle_count = 0;
        live_cells = 0;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            life_grid[r] = '0;
            saved_grid[r] = '0;
        end

        // Directed: empty grid, corners, a blinker, a still life on the border
        queue_cmd(CMD_READ, 0, 0, 1'b1);
        queue_cmd(CMD_EVOLVE, 0, 0, 1'b0);
        queue_cmd(CMD_SET, 63, 31, 1'b1);
        queue_cmd(CMD_SET, 0, 0, 1'b1);
        queue_cmd(CMD_READ, 63, 31, 1'b0);
        queue_cmd(CMD_EVOLVE, 0, 0, 1'b0);
        queue_cmd(CMD_EVOLVE, 63, 31, 1'b1);
        queue_cmd(CMD_RESTORE, 0, 0, 1'b0);
        queue_cmd(CMD_SET, 0, 0, 1'b0);
        queue_cmd(CMD_CLEAR, 0, 0, 1'b0);
        queue_cmd(CMD_RESTORE, 0, 0, 1'b0);
        queue_cmd(CMD_SET, 10, 5, 1'b1);
        queue_cmd(CMD_SET, 11, 5, 1'b1);
        queue_cmd(CMD_SET, 12, 5, 1'b1);
        queue_cmd(CMD_EVOLVE, 0, 0, 1'b0);
        queue_cmd(CMD_READ, 11, 4, 1'b0);
        queue_cmd(CMD_READ, 10, 5, 1'b0);
        queue_cmd(CMD_SPARE_LO, 11, 5, 1'b1);
        queue_cmd(CMD_SPARE_LO + 3'd1, 63, 31, 1'b1);
        queue_cmd(CMD_SPARE_HI, 42, 21, 1'b0);
        queue_cmd(CMD_CLEAR, 63, 31, 1'b1);
        queue_cmd(CMD_SET, 62, 30, 1'b1);
        queue_cmd(CMD_SET, 63, 30, 1'b1);
        queue_cmd(CMD_SET, 62, 31, 1'b1);
        queue_cmd(CMD_SET, 63, 31, 1'b1);
        queue_cmd(CMD_EVOLVE, 0, 0, 1'b0);
        queue_cmd(CMD_READ, 63, 31, 1'b0);

        // Random: seed a cluster, run it a few generations, probe it, add noise
        while (pending_cmds.size() < 27 + RANDOM_BEATS)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_cmd(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 31),
                          1'($urandom_range(0, 1)));
            base_c = $urandom_range(0, 63);
            base_r = $urandom_range(0, 31);
            repeat ($urandom_range(3, 12))
                queue_cmd(CMD_SET, base_c + $urandom_range(0, 4),
                          base_r + $urandom_range(0, 4), $urandom_range(0, 5) != 0);
            repeat ($urandom_range(1, 8))
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 5)
                    queue_cmd(CMD_EVOLVE, $urandom_range(0, 63), $urandom_range(0, 31),
                              1'($urandom_range(0, 1)));
                else if (pick <= 7)
                    queue_cmd(CMD_READ, base_c + $urandom_range(0, 6) - 1,
                              base_r + $urandom_range(0, 6) - 1, 1'($urandom_range(0, 1)));
                else if (pick == 8)
                    queue_cmd(CMD_RESTORE, $urandom_range(0, 63), $urandom_range(0, 31),
                              1'($urandom_range(0, 1)));
                else
                    queue_cmd(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                              $urandom_range(0, 63), $urandom_range(0, 31),
                              1'($urandom_range(0, 1)));
            end
        end
        total_cmds = pending_cmds.size();

        // Hold reset, release it away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (cmds_taken == total_cmds && expected_status.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
